>>> rtl/core/hashed_duplicate_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hashed duplicate detector
// Shared property wrappers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef HASHED_DUPLICATE_DETECTOR_DEFINES_SVH
`define HASHED_DUPLICATE_DETECTOR_DEFINES_SVH

// Same-cycle implication
`define HDD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hdd assertion failed");

// Next-cycle implication
`define HDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hdd assertion failed");

`endif

>>> rtl/core/hdd_pkg.sv
// ----------------------------------------------------------------------------
// hdd_pkg
// Sizes and shared types of the hashed duplicate detector.
// ----------------------------------------------------------------------------
package hdd_pkg;

   // Bucket geometry; BUCKETS must be a power of two
   localparam int BUCKETS      = 16;
   localparam int BUCKET_DEPTH = 8;
   localparam int VALUE_W      = 32;

   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int IDX_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
   localparam int ADDR_W = BKT_W + IDX_W;
   localparam int MEM_ENTRIES = BUCKETS << IDX_W;

   // Queue between front and back; power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   // Classified request as held in the queue
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [BKT_W-1:0]          bucket;
      logic                      first;
      logic                      last;
   } item_type;

endpackage

>>> rtl/core/hdd_front.sv
// ----------------------------------------------------------------------------
// hdd_front
// Accepts requests, picks the bucket and queues them for the back end.
// ----------------------------------------------------------------------------
module hdd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [hdd_pkg::VALUE_W-1:0]   req_value,
   input  logic                                 req_first,
   input  logic                                 req_last,
   output logic                                 q_valid,
   output hdd_pkg::item_type                    q_item,
   input  logic                                 q_pop
);

   hdd_pkg::item_type                entry_ff [hdd_pkg::QUEUE_DEPTH];
   logic [hdd_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hdd_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hdd_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             push;
   hdd_pkg::item_type                new_item;

   // Classify: bucket is the low bits, i.e. the non-negative residue
   always_comb begin
      new_item.value  = req_value;
      new_item.bucket = req_value[hdd_pkg::BKT_W-1:0];
      new_item.first  = req_first;
      new_item.last   = req_last;
   end

   assign req_stall = (count_ff == hdd_pkg::QCNT_W'(hdd_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> rtl/core/hdd_back.sv
// ----------------------------------------------------------------------------
// hdd_back
// Scans the chosen bucket one entry a cycle, inserts or flags, drives result.
// ----------------------------------------------------------------------------
`include "hashed_duplicate_detector_defines.svh"

module hdd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  hdd_pkg::item_type   q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_duplicate,
   output logic                rsp_all_distinct,
   output logic                rsp_overflow,
   output logic                rsp_done_res
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   localparam logic [hdd_pkg::FILL_W-1:0] DEPTH_CNT = hdd_pkg::FILL_W'(hdd_pkg::BUCKET_DEPTH);

   // Bucket store, contents undefined until written
   logic [hdd_pkg::VALUE_W-1:0]  mem [hdd_pkg::MEM_ENTRIES];
   logic [hdd_pkg::VALUE_W-1:0]  rd_data_ff;

   state_type                    state_ff;
   hdd_pkg::item_type            item_ff;
   logic [hdd_pkg::FILL_W-1:0]   fill_ff [hdd_pkg::BUCKETS];
   logic [hdd_pkg::FILL_W-1:0]   n_ff;
   logic [hdd_pkg::FILL_W-1:0]   scan_idx_ff;
   logic                         pend_ff;
   logic                         dup_ff;
   logic                         dup_seen_ff;
   logic                         ovf_seen_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_duplicate_ff;
   logic                         rsp_all_distinct_ff;
   logic                         rsp_overflow_ff;
   logic                         rsp_done_res_ff;

   logic                         rd_en;
   logic [hdd_pkg::ADDR_W-1:0]   rd_addr;
   logic [hdd_pkg::ADDR_W-1:0]   wr_addr;
   logic                         hit;
   logic                         out_free;
   logic                         ins;
   logic                         mem_we;
   logic                         dup_seen_new;
   logic                         ovf_seen_new;

   // Scan and insert control
   always_comb begin
      q_pop        = (state_ff == ST_IDLE) && q_valid;
      rd_en        = (state_ff == ST_SCAN) && (scan_idx_ff < n_ff);
      rd_addr      = {item_ff.bucket, scan_idx_ff[hdd_pkg::IDX_W-1:0]};
      wr_addr      = {item_ff.bucket, n_ff[hdd_pkg::IDX_W-1:0]};
      hit          = pend_ff && (rd_data_ff == item_ff.value);
      out_free     = !rsp_valid_ff || !rsp_stall;
      ins          = !dup_ff && (n_ff < DEPTH_CNT);
      mem_we       = (state_ff == ST_DONE) && out_free && ins;
      dup_seen_new = dup_seen_ff | dup_ff;
      ovf_seen_new = ovf_seen_ff | (!dup_ff && (n_ff == DEPTH_CNT));
   end

   // Bucket store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= item_ff.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // State, fill counts, sticky flags and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         dup_seen_ff  <= 1'b0;
         ovf_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < hdd_pkg::BUCKETS; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         // result drains here unless ST_DONE loads the next one
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  item_ff     <= q_item;
                  scan_idx_ff <= '0;
                  pend_ff     <= 1'b0;
                  dup_ff      <= 1'b0;
                  if (q_item.first) begin
                     n_ff        <= '0;
                     dup_seen_ff <= 1'b0;
                     ovf_seen_ff <= 1'b0;
                     for (int b = 0; b < hdd_pkg::BUCKETS; b++) begin
                        fill_ff[b] <= '0;
                     end
                  end else begin
                     n_ff <= fill_ff[q_item.bucket];
                  end
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_en) begin
                  scan_idx_ff <= scan_idx_ff + 1'b1;
               end
               pend_ff <= rd_en && !hit;
               // stop on a match, or once the last read has been compared
               if (hit) begin
                  dup_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else if (!rd_en) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_duplicate_ff    <= dup_ff;
                  rsp_all_distinct_ff <= !dup_seen_new;
                  rsp_overflow_ff     <= ovf_seen_new;
                  rsp_done_res_ff     <= item_ff.last;
                  dup_seen_ff         <= dup_seen_new;
                  ovf_seen_ff         <= ovf_seen_new;
                  if (ins) begin
                     fill_ff[item_ff.bucket] <= n_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duplicate    = rsp_duplicate_ff;
   assign rsp_all_distinct = rsp_all_distinct_ff;
   assign rsp_overflow     = rsp_overflow_ff;
   assign rsp_done_res     = rsp_done_res_ff;

   // Checks
   `HDD_ASSERT_IMP(a_scan_in_range, clock, reset, state_ff == ST_SCAN, scan_idx_ff <= n_ff)
   `HDD_ASSERT_IMP(a_count_bound, clock, reset, state_ff != ST_IDLE, n_ff <= DEPTH_CNT)
   `HDD_ASSERT_IMP(a_pend_only_scan, clock, reset, pend_ff, state_ff == ST_SCAN)
   `HDD_ASSERT_NEXT(a_done_gives_rsp, clock, reset, state_ff == ST_DONE && out_free, rsp_valid_ff)

endmodule

>>> rtl/core/hashed_duplicate_detector.sv
// ----------------------------------------------------------------------------
// hashed_duplicate_detector
// Flags repeated values within sets of a request stream, using a hash set
// of chained buckets.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one signed 32-bit value with first/last marks.
//   first clears all bucket fill counts and both sticky flags before the
//   value is handled; last is echoed on rsp_done_res.
//   Result channel (rsp_*): one result per request: duplicate flag, sticky
//   all_distinct and overflow flags of the current set, and done_res.
//   A request is taken when valid is high and stall is low.
//   Back end: a request passes the states idle, scan and done; the scan reads
//   every value of its bucket (at most BUCKET_DEPTH = 8) and ends early on a
//   match; the single read port of the bucket store scans one entry per cycle.
//   rsp_valid is registered, set as the back end leaves its done state.
//   A two-entry queue decouples intake from the scan, so requests are still
//   taken while a result waits; when the receiver stalls, the result holds
//   and the back end pauses once it has its next result ready.
//   Reset empties the queue, clears fill counts and flags; no clearing pass.
// ----------------------------------------------------------------------------
module hashed_duplicate_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [hdd_pkg::VALUE_W-1:0]   req_value,
   input  logic                                 req_first,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_duplicate,
   output logic                                 rsp_all_distinct,
   output logic                                 rsp_overflow,
   output logic                                 rsp_done_res
);

   logic                 q_valid;
   logic                 q_pop;
   hdd_pkg::item_type    q_item;

   // Intake and queue
   hdd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .req_first (req_first),
      .req_last  (req_last),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // Bucket scan and result
   hdd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duplicate    (rsp_duplicate),
      .rsp_all_distinct (rsp_all_distinct),
      .rsp_overflow     (rsp_overflow),
      .rsp_done_res     (rsp_done_res)
   );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the hashed duplicate detector
// Drives sets of signed values with first/last marks, predicts each result
// from its own copy of the bucket contents and sticky flags, and compares
// every result with the oldest prediction. A directed table comes first,
// then random sets under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;

   localparam int STALL_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int PHASE_REQUESTS = 205;
   localparam int REPORT_LIMIT   = 10;

   localparam logic signed [hdd_pkg::VALUE_W-1:0] MOST_NEGATIVE =
      {1'b1, {(hdd_pkg::VALUE_W-1){1'b0}}};
   localparam logic signed [hdd_pkg::VALUE_W-1:0] MOST_POSITIVE = ~MOST_NEGATIVE;
   localparam logic signed [hdd_pkg::VALUE_W-1:0] ALL_ONES      = '1;

   typedef struct packed {
      logic duplicate;
      logic all_distinct;
      logic overflow;
      logic done;
   } verdict_type;

   typedef struct {
      logic signed [hdd_pkg::VALUE_W-1:0] value;
      logic                               first;
      logic                               last;
      bit                                 typed;
      verdict_type                        want;
   } request_row_type;

   typedef enum int {POOL_MIX, ONE_BUCKET, SPREAD} value_mode_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic signed [hdd_pkg::VALUE_W-1:0] req_value;
   logic                               req_first;
   logic                               req_last;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic                               rsp_duplicate;
   logic                               rsp_all_distinct;
   logic                               rsp_overflow;
   logic                               rsp_done_res;

   // Predictor state: stored values, fill counts and sticky flags of the set
   logic [hdd_pkg::VALUE_W-1:0] kept_values [hdd_pkg::BUCKETS][hdd_pkg::BUCKET_DEPTH];
   int                          kept_count [hdd_pkg::BUCKETS];
   bit                          repeat_in_set;
   bit                          dropped_in_set;

   verdict_type     pending_verdicts [$];
   request_row_type directed_rows [$];
   int              req_idle_pct;
   int              rsp_idle_pct;
   int              mismatches   = 0;
   int              results_seen = 0;
   int              quiet_cycles = 0;

   hashed_duplicate_detector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_first        (req_first),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duplicate    (rsp_duplicate),
      .rsp_all_distinct (rsp_all_distinct),
      .rsp_overflow     (rsp_overflow),
      .rsp_done_res     (rsp_done_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Look the value up in its bucket, append it or drop it, update flags
   function automatic verdict_type classify_value(logic [hdd_pkg::VALUE_W-1:0] v,
                                                  logic f, logic l);
      logic [hdd_pkg::BKT_W-1:0] b;
      int                        n;
      bit                        hit;
      verdict_type               r;
      if (f) begin
         foreach (kept_count[i]) kept_count[i] = 0;
         repeat_in_set  = 1'b0;
         dropped_in_set = 1'b0;
      end
      b   = v[hdd_pkg::BKT_W-1:0];
      n   = kept_count[b];
      hit = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (kept_values[b][i] == v) hit = 1'b1;
      end
      if (hit) begin
         repeat_in_set = 1'b1;
      end else if (n < hdd_pkg::BUCKET_DEPTH) begin
         kept_values[b][n] = v;
         kept_count[b]     = n + 1;
      end else begin
         dropped_in_set = 1'b1;
      end
      r.duplicate    = hit;
      r.all_distinct = !repeat_in_set;
      r.overflow     = dropped_in_set;
      r.done         = l;
      return r;
   endfunction

   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", what);
   endfunction

   // Offer one request, holding it through any stall, then queue its verdict
   task automatic send_request(logic signed [hdd_pkg::VALUE_W-1:0] v, logic f, logic l,
                               bit typed, verdict_type want);
      verdict_type predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_first <= f;
      req_last  <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = classify_value(v, f, l);
      pending_verdicts.insert(pending_verdicts.size(), typed ? want : predicted);
   endtask

   // Hold off the sender until every outstanding result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(logic signed [hdd_pkg::VALUE_W-1:0] v, logic f, logic l,
                          bit typed, logic dup, logic distinct, logic ovf);
      request_row_type row;
      row.value = v;
      row.first = f;
      row.last  = l;
      row.typed = typed;
      row.want  = '{duplicate: dup, all_distinct: distinct, overflow: ovf, done: l};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // One random set; mostly well formed, sometimes without its first or last mark
   task automatic send_random_set(output int sent);
      logic signed [hdd_pkg::VALUE_W-1:0] pool [16];
      logic signed [hdd_pkg::VALUE_W-1:0] v;
      value_mode_type                     mode;
      int                                 len;
      int                                 span;
      logic [hdd_pkg::BKT_W-1:0]          home;
      logic                               opens;
      logic                               closes;
      logic                               f;
      logic                               l;
      mode   = value_mode_type'($urandom_range(0, 2));
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      span   = $urandom_range(2, 15);
      home   = hdd_pkg::BKT_W'($urandom_range(0, hdd_pkg::BUCKETS - 1));
      opens  = ($urandom_range(0, 9) != 0);
      closes = ($urandom_range(0, 9) != 0);
      foreach (pool[i]) begin
         case ($urandom_range(0, 11))
            0:       pool[i] = MOST_NEGATIVE;
            1:       pool[i] = MOST_POSITIVE;
            2:       pool[i] = '0;
            3:       pool[i] = ALL_ONES;
            default: pool[i] = $urandom();
         endcase
      end
      for (int k = 0; k < len; k++) begin
         case (mode)
            POOL_MIX: v = pool[4'($urandom_range(0, span))];
            ONE_BUCKET: begin
               // crowd one bucket past its depth
               v = pool[4'($urandom_range(0, 15))];
               v[hdd_pkg::BKT_W-1:0] = home;
            end
            default: v = $urandom();
         endcase
         f = (k == 0) ? opens : ($urandom_range(0, 49) == 0);
         l = (k == len - 1) ? closes : ($urandom_range(0, 49) == 0);
         send_request(v, f, l, 1'b0, '0);
      end
      sent = len;
   endtask

   // Result checking, receiver stalls and the no-progress watchdog
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_idle_pct);
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_duplicate, rsp_all_distinct, rsp_overflow, rsp_done_res};
            results_seen++;
            if (pending_verdicts.size() == 0) begin
               note_mismatch($sformatf("result %0d arrived with no request outstanding",
                                       results_seen));
            end else begin
               want = pending_verdicts.pop_front();
               if (got !== want)
                  note_mismatch($sformatf(
                     "result %0d: dup/distinct/ovf/done expected %b %b %b %b got %b %b %b %b",
                     results_seen, want.duplicate, want.all_distinct, want.overflow,
                     want.done, got.duplicate, got.all_distinct, got.overflow, got.done));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      int n;
      int in_phase;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_value    <= '0;
      req_first    <= 1'b0;
      req_last     <= 1'b0;
      req_idle_pct  = 20;
      rsp_idle_pct  = 64;

      // no first mark yet: the empty set left by reset is used
      add_row(5,             1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      add_row(5,             1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      // first clears the set, so 5 is new again
      add_row(5,             1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      add_row(MOST_NEGATIVE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      add_row(MOST_POSITIVE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      add_row(ALL_ONES,      1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      add_row(0,             1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      add_row(ALL_ONES,      1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      // after last without first the set carries on
      add_row(MOST_POSITIVE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
      // fill bucket 3 to its depth, negative member included
      add_row(3,             1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
      add_row(19,            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(35,            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(51,            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(-13,           1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(67,            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(83,            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      add_row(99,            1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      // full bucket drops the value; its repeat is not a duplicate
      add_row(115,           1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
      add_row(115,           1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
      add_row(19,            1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
      // a new set clears the sticky overflow
      add_row(0,             1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].value, directed_rows[i].first, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      // random sets: sender idles lightly, then heavily, then not at all
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 64 : 0;
         rsp_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 20 : 0;
         in_phase = 0;
         while (in_phase < PHASE_REQUESTS) begin
            send_random_set(n);
            in_phase += n;
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/hdd_pkg.sv
rtl/core/hdd_front.sv
rtl/core/hdd_back.sv
rtl/core/hashed_duplicate_detector.sv
sim/testbench.sv
